### design/pla_pkg.sv
`timescale 1ns / 1ps
package pla_pkg;

    localparam int DEF_CAPACITY   = 128;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int OPCODE_W  = 2;
    localparam int POS_W     = 8;
    localparam int FDATA_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int FCOUNT_W  = 8;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [POS_W-1:0]         position;
        logic signed [FDATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [FDATA_W-1:0] data;
        logic [STATUS_W-1:0]       status;
        logic [FCOUNT_W-1:0]       count;
        logic                      is_empty;
        logic                      is_full;
    } t_rsp;

    typedef struct packed {
        logic ins;
        logic del;
    } t_shift_cmd;

endpackage

### design/pla_cell.sv
`timescale 1ns / 1ps
module pla_cell
    import pla_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int CW         = 8,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_shift_cmd            i_cmd,
    input  logic [CW-1:0]         i_pos,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_prev,
    input  logic [DATA_WIDTH-1:0] i_next,
    output logic [DATA_WIDTH-1:0] o_entry
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DATA_WIDTH-1:0] r_entry;
    logic [DATA_WIDTH-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (MY_IDX > i_pos) begin
                n_entry = i_prev;
            end else if (MY_IDX == i_pos) begin
                n_entry = i_value;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_pos) begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### design/positional_array_list_top.sv
`timescale 1ns / 1ps
// positional array list: ordered list of values held in a row of shifting cells
// request channel (i_req_valid / o_req_stall) carries opcode, position and value:
//   insert at position, append, delete at position, read at position
// response channel (o_rsp_valid / i_rsp_stall) returns one response per request
//   with data, status (ok, position error, full), count and empty / full flags
// the response is registered and shows in the cycle after the request is taken
// throughput: one request per cycle unless stalled; insert and delete move
//   every later cell by one place in that same cycle, read muxes all cells
// a request that fails its check leaves the list untouched
// reset clears the count and the response valid; cell contents are not cleared
//   and are only read below the count, so no clearing pass is needed
// when the receiver stalls, the response holds and the request side stalls
//   for every cycle that the held response is still waiting
module positional_array_list_top
    import pla_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam int OW = (DATA_WIDTH > FDATA_W) ? DATA_WIDTH : FDATA_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_rsp_valid;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;
    t_shift_cmd            w_cmd;
    logic [CW-1:0]         w_cmd_pos;
    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_entry [CAPACITY];
    logic [XW-1:0]         w_pos_x;
    logic [XW-1:0]         w_cnt_x;
    logic [XW-1:0]         w_ncnt_x;
    logic [OW-1:0]         w_rd_x;
    logic                  w_full;
    logic                  w_accept;

    assign o_req_stall = r_rsp_valid & i_rsp_stall;
    assign w_accept    = i_req_valid & ~o_req_stall;

    assign w_value  = DATA_WIDTH'(OW'(unsigned'(i_req.value)));
    assign w_pos_x  = XW'(i_req.position);
    assign w_cnt_x  = XW'(r_count);
    assign w_full   = (r_count == CAP_C);
    assign w_rd_x   = OW'(w_entry[w_pos_x[IW-1:0]]);
    assign w_ncnt_x = XW'(n_count);

    always_comb begin
        w_cmd     = '0;
        w_cmd_pos = r_count;
        n_count   = r_count;
        n_rsp     = '0;
        n_rsp.status = ST_OK;
        unique case (i_req.opcode)
            OP_INSERT: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    n_rsp.status = ST_POS;
                end else begin
                    w_cmd.ins = 1'b1;
                    w_cmd_pos = w_pos_x[CW-1:0];
                    n_count   = r_count + CW'(1);
                end
            end
            OP_APPEND: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_DELETE, OP_READ: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_rsp.status = ST_POS;
                end else begin
                    n_rsp.data = signed'(w_rd_x[FDATA_W-1:0]);
                    w_cmd_pos  = w_pos_x[CW-1:0];
                    if (i_req.opcode == OP_DELETE) begin
                        w_cmd.del = 1'b1;
                        n_count   = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_rsp.status = ST_POS;
            end
        endcase
        if (!w_accept) begin
            w_cmd   = '0;
            n_count = r_count;
        end
        n_rsp.count    = w_ncnt_x[FCOUNT_W-1:0];
        n_rsp.is_empty = (n_count == '0);
        n_rsp.is_full  = (n_count == CAP_C);
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        logic [DATA_WIDTH-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_entry[g+1];
        end
        pla_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_cmd_pos),
            .i_value (w_value),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
